// File: rtl/core/pffs_pkg.sv
package pffs_pkg;

    // fixed field widths
    localparam int RAD_W   = 15;
    localparam int GAIN_W  = 16;
    localparam int MAG_W   = 16;
    localparam int REG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int OUT_W   = 32;
    localparam int FRAC_W  = 12;
    localparam int QUO_W   = 21;
    localparam int PUSH_W  = 30;

    // core push of 1000000.0 in signed Q21.8
    localparam logic signed [PUSH_W-1:0] CORE_PUSH = 30'sd256000000;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_GOAL_X      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_GOAL_Y      = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GOAL_RADIUS = 3'd2;
    localparam logic [ADDR_W-1:0] REG_GOAL_SPREAD = 3'd3;
    localparam logic [ADDR_W-1:0] REG_GOAL_GAIN   = 3'd4;

    // register reset values
    localparam logic [RAD_W-1:0]  GOAL_RADIUS_RST = 15'd512;
    localparam logic [RAD_W-1:0]  GOAL_SPREAD_RST = 15'd512;
    localparam logic [GAIN_W-1:0] GOAL_GAIN_RST   = 16'd4096;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: rtl/core/potential_field_force_sum.sv
// potential field force accumulator
// input channel s_*: one word per obstacle, with the robot position for the run.
// first_of_run reloads the sum with the goal attraction, has_obstacle adds the
// obstacle force, last_of_run sends the saturated total on the m_* channel.
// cfg_*: goal registers, to be written by the user only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.
// each force term (goal or obstacle) runs the states offset, squaring x and y,
// square root, zone, multiply (gain, x numerator, y numerator), division and
// accumulate; zone results without a scaled term skip the multiply and divide.
// a word is accepted in the idle state; a word carrying both a goal and an
// obstacle term runs the sequence twice, and a last word then passes through emit.
// the square root and the two divisions (x and y in parallel) are bit serial
// and set the latency; one word is worked on at a time.
// the result sits in an output register, so the next word is accepted while
// the receiver stalls; a word that must emit waits until that register is free.
// reset clears the running sum to zero and loads the goal register defaults.
module potential_field_force_sum #(
    parameter int COORD_WIDTH = 16,
    parameter int FORCE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_robot_x,
    input  logic signed [COORD_WIDTH-1:0]         s_robot_y,
    input  logic signed [COORD_WIDTH-1:0]         s_obstacle_x,
    input  logic signed [COORD_WIDTH-1:0]         s_obstacle_y,
    input  logic [pffs_pkg::RAD_W-1:0]            s_obstacle_radius,
    input  logic [pffs_pkg::RAD_W-1:0]            s_obstacle_spread,
    input  logic [pffs_pkg::GAIN_W-1:0]           s_obstacle_gain,
    input  logic                                  s_has_obstacle,
    input  logic                                  s_first_of_run,
    input  logic                                  s_last_of_run,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pffs_pkg::OUT_W-1:0]     m_force_x,
    output logic signed [pffs_pkg::OUT_W-1:0]     m_force_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pffs_pkg::ADDR_W-1:0]           cfg_addr,
    input  logic [pffs_pkg::REG_W-1:0]            cfg_data
);
    import pffs_pkg::*;

    // widths
    localparam int OW  = ((COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W) + 1; // offset, root
    localparam int SQW = 2 * OW;
    localparam int MA  = (OW > 32) ? OW : 32;
    localparam int PW  = MA + OW;
    localparam int DW  = OW + FRAC_W;
    localparam int NW  = DW + QUO_W;
    localparam int ZW  = OW + 2;
    localparam int AW  = ((FORCE_WIDTH > PUSH_W) ? FORCE_WIDTH : PUSH_W) + 2;

    localparam logic signed [AW-1:0] FMAX = {{(AW-FORCE_WIDTH+1){1'b0}}, {(FORCE_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] FMIN = ~FMAX;
    localparam logic signed [AW-1:0] OMAX = {{(AW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [AW-1:0] OMIN = ~OMAX;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_OFS  = 4'd1;
    localparam logic [3:0] ST_SQX  = 4'd2;
    localparam logic [3:0] ST_SQY  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_ZONE = 4'd5;
    localparam logic [3:0] ST_GM   = 4'd6;
    localparam logic [3:0] ST_NUMX = 4'd7;
    localparam logic [3:0] ST_NUMY = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_ACC  = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;

    // zone of the current term
    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_CORE  = 2'd1;
    localparam logic [1:0] MODE_SCALE = 2'd2;

    // goal registers
    logic signed [REG_W-1:0] goal_x_reg, goal_y_reg;
    logic [RAD_W-1:0]        goal_radius_reg, goal_spread_reg;
    logic [GAIN_W-1:0]       goal_gain_reg;

    // latched word
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg, obx_reg, oby_reg;
    logic [RAD_W-1:0]              orad_reg, ospr_reg;
    logic [GAIN_W-1:0]             ogain_reg;
    logic                          has_reg, last_reg;

    logic [3:0]              state_reg, state_next;
    logic                    phase_reg, phase_next;   // 0 goal, 1 obstacle
    logic signed [OW-1:0]    ox_reg, oy_reg;
    logic [SQW-1:0]          sq_reg;
    logic [1:0]              mode_reg, mode_next;
    logic [MAG_W-1:0]        m_reg, m_next;
    logic [31:0]             gm_reg;
    logic [NW-1:0]           numx_reg;
    logic signed [FORCE_WIDTH-1:0] sum_x_reg, sum_y_reg;
    logic signed [OUT_W-1:0] fx_out_reg, fy_out_reg;
    logic                    m_valid_reg;

    logic                    accept;
    logic signed [OW-1:0]    px, py, pr_x, pr_y;
    logic [OW-1:0]           absx, absy;
    logic [MA-1:0]           mul_a;
    logic [OW-1:0]           mul_b;
    logic [PW-1:0]           prod;
    logic [SQW-1:0]          rad_in;
    logic [NW-1:0]           num_cur;
    logic [OW-1:0]           d_root;
    logic [QUO_W-1:0]        qx, qy;
    unit_stat_t              sq_stat, dx_stat, dy_stat;
    logic                    emit_ok;

    logic [ZW-1:0]           dz, rz, rsz, diff_lo, diff_hi;
    logic signed [AW-1:0]    add_x, add_y, base_x, base_y, tot_x, tot_y;
    logic signed [AW-1:0]    sx_ext, sy_ext;
    logic signed [FORCE_WIDTH-1:0] sat_x, sat_y;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign emit_ok   = !m_valid_reg || m_ready;

    // offsets and magnitudes
    assign px   = phase_reg ? OW'(obx_reg) : OW'(goal_x_reg);
    assign py   = phase_reg ? OW'(oby_reg) : OW'(goal_y_reg);
    assign pr_x = OW'(rx_reg);
    assign pr_y = OW'(ry_reg);
    assign absx = ox_reg[OW-1] ? OW'(-ox_reg) : OW'(ox_reg);
    assign absy = oy_reg[OW-1] ? OW'(-oy_reg) : OW'(oy_reg);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = MA'(absx);
                mul_b = absx;
            end
            ST_SQY: begin
                mul_a = MA'(absy);
                mul_b = absy;
            end
            ST_GM: begin
                mul_a = MA'(phase_reg ? ogain_reg : goal_gain_reg);
                mul_b = OW'(m_reg);
            end
            ST_NUMX: begin
                mul_a = MA'(gm_reg);
                mul_b = absx;
            end
            ST_NUMY: begin
                mul_a = MA'(gm_reg);
                mul_b = absy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod    = mul_a * PW'(mul_b);
    assign rad_in  = sq_reg + prod[SQW-1:0];
    // gain*m*|o| plus half the divisor for rounding
    assign num_cur = NW'(prod[NW-2:0]) + NW'({d_root, 11'b0});

    pffs_isqrt #(.RW(OW)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_SQY),
        .radicand (rad_in),
        .root     (d_root),
        .stat     (sq_stat)
    );

    pffs_div #(.DW(DW), .QW(QUO_W)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_NUMY),
        .dividend (numx_reg),
        .divisor  ({d_root, {FRAC_W{1'b0}}}),
        .quotient (qx),
        .stat     (dx_stat)
    );

    pffs_div #(.DW(DW), .QW(QUO_W)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_NUMY),
        .dividend (num_cur),
        .divisor  ({d_root, {FRAC_W{1'b0}}}),
        .quotient (qy),
        .stat     (dy_stat)
    );

    // zone decision on the distance
    always_comb begin
        dz  = ZW'(d_root);
        rz  = phase_reg ? ZW'(orad_reg) : ZW'(goal_radius_reg);
        rsz = rz + (phase_reg ? ZW'(ospr_reg) : ZW'(goal_spread_reg));
        diff_lo = dz - rz;
        diff_hi = rsz - dz;
        mode_next = MODE_ZERO;
        m_next    = m_reg;
        if (d_root == '0) begin
            mode_next = MODE_ZERO;
        end else if (!phase_reg) begin
            if (dz >= rz) begin
                mode_next = MODE_SCALE;
                m_next = (dz <= rsz) ? diff_lo[MAG_W-1:0] : MAG_W'(goal_spread_reg);
            end
        end else if (dz < rz) begin
            mode_next = MODE_CORE;
        end else if (dz <= rsz) begin
            mode_next = MODE_SCALE;
            m_next = diff_hi[MAG_W-1:0];
        end
    end

    // addends, obstacle terms pull the other way
    always_comb begin
        add_x = '0;
        add_y = '0;
        case (mode_reg)
            MODE_CORE: begin
                if (ox_reg > 0) add_x = -AW'(CORE_PUSH);
                else if (ox_reg < 0) add_x = AW'(CORE_PUSH);
                if (oy_reg > 0) add_y = -AW'(CORE_PUSH);
                else if (oy_reg < 0) add_y = AW'(CORE_PUSH);
            end
            MODE_SCALE: begin
                add_x = (ox_reg[OW-1] ^ phase_reg) ? -AW'(qx) : AW'(qx);
                add_y = (oy_reg[OW-1] ^ phase_reg) ? -AW'(qy) : AW'(qy);
            end
            default: begin
                add_x = '0;
                add_y = '0;
            end
        endcase
        base_x = phase_reg ? AW'(sum_x_reg) : '0;
        base_y = phase_reg ? AW'(sum_y_reg) : '0;
        tot_x  = base_x + add_x;
        tot_y  = base_y + add_y;
        if (tot_x > FMAX) sat_x = FMAX[FORCE_WIDTH-1:0];
        else if (tot_x < FMIN) sat_x = FMIN[FORCE_WIDTH-1:0];
        else sat_x = tot_x[FORCE_WIDTH-1:0];
        if (tot_y > FMAX) sat_y = FMAX[FORCE_WIDTH-1:0];
        else if (tot_y < FMIN) sat_y = FMIN[FORCE_WIDTH-1:0];
        else sat_y = tot_y[FORCE_WIDTH-1:0];
        sx_ext = AW'(sum_x_reg);
        sy_ext = AW'(sum_y_reg);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_first_of_run) begin
                        phase_next = 1'b0;
                        state_next = ST_OFS;
                    end else if (s_has_obstacle) begin
                        phase_next = 1'b1;
                        state_next = ST_OFS;
                    end else if (s_last_of_run) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_OFS:  state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SQRT;
            ST_SQRT: if (sq_stat.done) state_next = ST_ZONE;
            ST_ZONE: state_next = (mode_next == MODE_SCALE) ? ST_GM : ST_ACC;
            ST_GM:   state_next = ST_NUMX;
            ST_NUMX: state_next = ST_NUMY;
            ST_NUMY: state_next = ST_DIV;
            ST_DIV:  if (dy_stat.done) state_next = ST_ACC;
            ST_ACC: begin
                if (!phase_reg && has_reg) begin
                    phase_next = 1'b1;
                    state_next = ST_OFS;
                end else begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: if (emit_ok) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rx_reg    <= s_robot_x;
            ry_reg    <= s_robot_y;
            obx_reg   <= s_obstacle_x;
            oby_reg   <= s_obstacle_y;
            orad_reg  <= s_obstacle_radius;
            ospr_reg  <= s_obstacle_spread;
            ogain_reg <= s_obstacle_gain;
            has_reg   <= s_has_obstacle;
            last_reg  <= s_last_of_run;
        end
        if (state_reg == ST_OFS) begin
            ox_reg <= px - pr_x;
            oy_reg <= py - pr_y;
        end
        if (state_reg == ST_SQX) sq_reg <= prod[SQW-1:0];
        if (state_reg == ST_ZONE) begin
            mode_reg <= mode_next;
            m_reg    <= m_next;
        end
        if (state_reg == ST_GM) gm_reg <= prod[31:0];
        if (state_reg == ST_NUMX) numx_reg <= num_cur;
        if (state_reg == ST_EMIT && emit_ok) begin
            fx_out_reg <= (sx_ext > OMAX) ? OMAX[OUT_W-1:0] :
                          (sx_ext < OMIN) ? OMIN[OUT_W-1:0] : sx_ext[OUT_W-1:0];
            fy_out_reg <= (sy_ext > OMAX) ? OMAX[OUT_W-1:0] :
                          (sy_ext < OMIN) ? OMIN[OUT_W-1:0] : sy_ext[OUT_W-1:0];
        end
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            m_valid_reg     <= 1'b0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            goal_radius_reg <= GOAL_RADIUS_RST;
            goal_spread_reg <= GOAL_SPREAD_RST;
            goal_gain_reg   <= GOAL_GAIN_RST;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (state_reg == ST_ACC) begin
                sum_x_reg <= sat_x;
                sum_y_reg <= sat_y;
            end
            if (state_reg == ST_EMIT && emit_ok) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_GOAL_X:      goal_x_reg      <= cfg_data;
                    REG_GOAL_Y:      goal_y_reg      <= cfg_data;
                    REG_GOAL_RADIUS: goal_radius_reg <= cfg_data[RAD_W-1:0];
                    REG_GOAL_SPREAD: goal_spread_reg <= cfg_data[RAD_W-1:0];
                    REG_GOAL_GAIN:   goal_gain_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_force_x = fx_out_reg;
    assign m_force_y = fy_out_reg;

    // one word at a time; a word with nothing to do leaves the block idle
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_first_of_run || s_has_obstacle || s_last_of_run) |=> !s_ready)
        else $error("word accepted while busy");

    // root unit only runs while the sequencer waits on it
    a_sqrt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_stat.busy |-> state_reg == ST_SQRT)
        else $error("square root running out of sequence");

    // dividers run in lockstep
    a_div_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_stat.busy == dy_stat.busy)
        else $error("dividers out of step");

    // a result appears only from the emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result without emit");

endmodule

// File: rtl/core/pffs_isqrt.sv
module pffs_isqrt #(
    parameter int RW = 17
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [2*RW-1:0]        radicand,
    output logic [RW-1:0]          root,
    output pffs_pkg::unit_stat_t   stat
);
    import pffs_pkg::*;

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW:0]     rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW+2:0]   tv, tr, td;

    // one root bit per cycle, two radicand bits brought down
    always_comb begin
        tv = {rem_reg, rad_reg[2*RW-1 -: 2]};
        tr = {1'b0, root_reg, 2'b01};
        td = tv - tr;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[2*RW-3:0], 2'b00};
            if (tv >= tr) begin
                rem_next  = td[RW:0];
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = tv[RW:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/core/pffs_div.sv
module pffs_div #(
    parameter int DW = 29,
    parameter int QW = 21
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DW+QW-1:0]       dividend,
    input  logic [DW-1:0]          divisor,
    output logic [QW-1:0]          quotient,
    output pffs_pkg::unit_stat_t   stat
);
    import pffs_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [QW-1:0] lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   tv, td;

    // restoring division, one quotient bit per cycle
    always_comb begin
        tv = {rem_reg, lo_reg[QW-1]};
        td = tv - {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[DW+QW-1:QW];
            lo_next   = dividend[QW-1:0];
            den_next  = divisor;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (tv >= {1'b0, den_reg}) begin
                rem_next = td[DW-1:0];
                lo_next  = {lo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = tv[DW-1:0];
                lo_next  = {lo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = lo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
